// ----- src/dpa_pkg.sv -----
// ----------------------------------------------------------------------------
// dpa_pkg: shared constants and helpers for the binary64 adder
// field widths, special encodings and the leading-zero count helper
// ----------------------------------------------------------------------------
`default_nettype none

package dpa_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned ExpW  = 11;
	localparam int unsigned FracW = 52;
	localparam int unsigned ManW  = 53;
	localparam int unsigned LzW   = 6;

	localparam logic [ExpW-1:0]  ExpMax    = 11'h7ff;
	localparam logic [WordW-1:0] QnanCanon = 64'h7ff8_0000_0000_0000;

	// special-case outcome carried down the pipe
	typedef struct packed {
		logic             take;
		logic [WordW-1:0] value;
	} special_t;

	// leading zeros of a 53-bit significand (53 when zero)
	function automatic logic [LzW-1:0] lzc53(input logic [ManW-1:0] v);
		logic [LzW-1:0] n;
		logic           found;
		n     = LzW'(ManW);
		found = 1'b0;
		for (int i = ManW - 1; i >= 0; i--) begin
			if (!found && v[i]) begin
				n     = LzW'(ManW - 1 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ----- src/double_precision_adder.sv -----
// ----------------------------------------------------------------------------
// double_precision_adder: pipelined binary64 adder
// Adds two IEEE 754 binary64 operands with round toward zero and flush to zero.
//
// Use: operand_a/operand_b enter on in_valid/in_ready; sum_value leaves on
// out_valid/out_ready. Both channels transfer a transaction on a clock edge
// where valid and ready are both high.
// Throughput: one transaction per cycle while out_ready is high; the
// four register stages (unpack/compare, align, add, normalise) each hold one item.
// Stall: when out_ready is low, a stage only advances into an empty slot, so
// bubbles are squeezed out and in_ready drops once all stages are full; no
// transaction is lost or repeated.
// Reset: arst_n clears every stage valid bit; the pipe comes up empty and
// in_ready is high.
// NaN in gives 0x7ff8000000000000; subnormals count as zero; underflow gives
// zero and overflow gives infinity.
// ----------------------------------------------------------------------------
`default_nettype none

module double_precision_adder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] operand_a,
	input  wire logic [63:0] operand_b,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      sum_value
);

	localparam int unsigned EW = dpa_pkg::ExpW;
	localparam int unsigned MW = dpa_pkg::ManW;

	// stage enables: advance when the slot ahead empties or is free
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	// stage 1: special cases and magnitude ordering
	dpa_pkg::special_t sp_s1, sp_s2, sp_s3, sp_s4;
	logic          sx_s1, sub_s1;
	logic [EW-1:0] ex_s1, ey_s1;
	logic [MW-1:0] mx_s1, my_s1;

	dpa_pkg::special_t sp_c;
	logic [EW-1:0] ea, eb;
	logic [51:0]   fa, fb;
	logic          swap;
	always_comb begin
		ea   = operand_a[62:52];
		eb   = operand_b[62:52];
		fa   = operand_a[51:0];
		fb   = operand_b[51:0];
		swap = operand_a[62:0] < operand_b[62:0];
		sp_c = '{take: 1'b1, value: operand_a};
		priority if ((ea == dpa_pkg::ExpMax && fa != '0) ||
				(eb == dpa_pkg::ExpMax && fb != '0))
			sp_c.value = dpa_pkg::QnanCanon;
		else if (ea == dpa_pkg::ExpMax && eb == dpa_pkg::ExpMax)
			sp_c.value = (operand_a[63] != operand_b[63]) ? dpa_pkg::QnanCanon : operand_a;
		else if (ea == dpa_pkg::ExpMax)
			sp_c.value = operand_a;
		else if (eb == dpa_pkg::ExpMax)
			sp_c.value = operand_b;
		else if (ea == '0 && eb == '0)
			sp_c.value = {operand_a[63] & operand_b[63], 63'd0};
		else if (ea == '0)
			sp_c.value = operand_b;
		else if (eb == '0)
			sp_c.value = operand_a;
		else
			sp_c.take = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en1) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sp_s1  <= sp_c;
			sx_s1  <= swap ? operand_b[63] : operand_a[63];
			sub_s1 <= operand_a[63] ^ operand_b[63];
			ex_s1  <= swap ? eb : ea;
			ey_s1  <= swap ? ea : eb;
			mx_s1  <= {1'b1, swap ? fb : fa};
			my_s1  <= {1'b1, swap ? fa : fb};
		end
	end

	// stage 2: align the smaller significand
	logic          sx_s2, sub_s2;
	logic [EW-1:0] ex_s2;
	logic [MW-1:0] mx_s2, my_s2;
	logic [EW-1:0] align_sh;
	assign align_sh = ex_s1 - ey_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			sp_s2  <= sp_s1;
			sx_s2  <= sx_s1;
			sub_s2 <= sub_s1;
			ex_s2  <= ex_s1;
			mx_s2  <= mx_s1;
			my_s2  <= (align_sh >= EW'(MW)) ? '0 : (my_s1 >> align_sh);
		end
	end

	// stage 3: add or subtract
	logic          sx_s3, sub_s3;
	logic [EW-1:0] ex_s3;
	logic [MW:0]   sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en3) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			sp_s3  <= sp_s2;
			sx_s3  <= sx_s2;
			sub_s3 <= sub_s2;
			ex_s3  <= ex_s2;
			sum_s3 <= sub_s2 ? ({1'b0, mx_s2} - {1'b0, my_s2}) : ({1'b0, mx_s2} + {1'b0, my_s2});
		end
	end

	// stage 4: normalise and pack
	logic [dpa_pkg::LzW-1:0] lz;
	logic [EW:0]    e_up;
	logic [EW+1:0]  e_dn;
	logic [MW-1:0]  m_sh;
	logic [63:0]    packed_c;
	always_comb begin
		lz       = dpa_pkg::lzc53(sum_s3[MW-1:0]);
		e_up     = {1'b0, ex_s3} + (EW+1)'(1);
		e_dn     = {2'b00, ex_s3} - (EW+2)'(lz);
		m_sh     = sum_s3[MW-1:0] << lz;
		packed_c = '0;
		if (sp_s3.take)
			packed_c = sp_s3.value;
		else if (!sub_s3) begin
			if (sum_s3[MW]) begin
				if (e_up >= (EW+1)'(dpa_pkg::ExpMax))
					packed_c = {sx_s3, dpa_pkg::ExpMax, 52'd0};
				else
					packed_c = {sx_s3, e_up[EW-1:0], sum_s3[MW-1:1]};
			end else if (ex_s3 == dpa_pkg::ExpMax)
				packed_c = {sx_s3, dpa_pkg::ExpMax, 52'd0};
			else
				packed_c = {sx_s3, ex_s3, sum_s3[51:0]};
		end else if (sum_s3 == '0)
			packed_c = '0;
		else if (e_dn[EW+1] || e_dn == '0)
			packed_c = {sx_s3, 63'd0};
		else
			packed_c = {sx_s3, e_dn[EW-1:0], m_sh[51:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en4) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en4) sum_value <= packed_c;
	end
	assign sp_s4 = sp_s3;
	assign out_valid = v_s4;

	// a held result must not move while the receiver stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sum_value))
		else $error("result changed under stall");
	// a full pipe with a stalled output refuses input
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && v_s4 && !out_ready |-> !in_ready)
		else $error("input taken into full pipe");
	// special outcome never lost across the last stage
	a_spec: assert property (@(posedge clk) disable iff (!arst_n)
		en4 && v_s3 && sp_s4.take |=> sum_value == $past(sp_s4.value))
		else $error("special result lost");

endmodule

`default_nettype wire
